FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

FILE: rtl/core/mwdpf_pkg.sv
// ----------------------------------------------------------------------------
// Multi-width derivative peak finder package
// Sizes, payload types and codes shared by the peak finder files.
// ----------------------------------------------------------------------------
package mwdpf_pkg;

  localparam int MAX_WIDTH   = 12;
  localparam int MIN_WIDTH   = 6;
  localparam int MAX_PEAKS   = 100;
  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int NUM_WIDTHS = MAX_WIDTH - MIN_WIDTH + 1;
  localparam int HIST_DEPTH = MAX_WIDTH + 1;
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int TAP_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int IDX_W      = $clog2(MAX_SAMPLES);
  localparam int PNUM_W     = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int CNT_W      = $clog2(MAX_PEAKS + 1);
  localparam int SLOPE_W    = SAMPLE_BITS + 2;
  localparam int CMP_W      = SLOPE_W + 2;

  localparam int DTHR_W     = 18;
  localparam int STHR_W     = 17;
  localparam int CFG_DATA_W = DTHR_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DTHR_W-1:0] DERIV_RST = DTHR_W'(40);
  localparam logic [DTHR_W-1:0] RISE_RST  = DTHR_W'(56);
  localparam logic [STHR_W-1:0] STEP_RST  = STHR_W'(23);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DERIV = 2'd0,
    REG_RISE  = 2'd1,
    REG_STEP  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_NEW     = 2'd0,
    KIND_REPLACE = 2'd1,
    KIND_DONE    = 2'd2
  } kind_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SLOPE_W-1:0]     slope_t;

  typedef struct packed {
    logic [DTHR_W-1:0] deriv;
    logic [DTHR_W-1:0] rise;
    logic [STHR_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    sample_t sample;
    logic    end_of_waveform;
  } in_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [PNUM_W-1:0] peak_number;
    logic [IDX_W-1:0]  position;
    sample_t           height;
    logic [CNT_W-1:0]  peak_count;
  } out_item_t;

endpackage

FILE: rtl/core/mwdpf_if.sv
// ----------------------------------------------------------------------------
// Peak finder channels
// Valid/ready channels for input samples and result items.
// ----------------------------------------------------------------------------
interface mwdpf_in_if import mwdpf_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface mwdpf_out_if import mwdpf_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/core/multi_width_derivative_peak_finder.sv
// ----------------------------------------------------------------------------
// Multi-width derivative peak finder
// Tests a row of slope widths on every sample once the history is full and
// reports new and replaced peaks, then the peak count at each waveform's end.
//
//   channel  dir  handshake    payload
//   in_i     in   valid/ready  sample, end_of_waveform
//   out_o    out  valid/ready  kind, peak_number, position, height, peak_count
//   cfg      in   cfg_we_i     cfg_idx_i, cfg_data_i
//
// One item per cycle while in_i.ready is high; its result is registered.
// All width cells evaluate in the accepting cycle, then a single output stage.
// in_i.ready drops only while a result is held and out_o.ready is low.
// Reset is asynchronous; thresholds return to 40, 56, 23.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_width_derivative_peak_finder import mwdpf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mwdpf_in_if.sink              in_i,
  mwdpf_out_if.source           out_o
);

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);

  cfg_t              cfg_q;
  sample_t           hist_q [HIST_DEPTH];
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  last_q, last_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic                  acc;
  logic                  eow;
  logic                  eval;
  logic                  en;
  logic [NUM_WIDTHS:0]   taken;
  logic [NUM_WIDTHS-1:0] win;
  logic [WID_W-1:0]      fired_w;
  logic                  emit;
  logic                  is_new;
  logic [CNT_W-1:0]      num;

  assign acc  = in_i.valid && in_i.ready;
  assign eow  = in_i.item.end_of_waveform;
  assign eval = idx_q >= IDX_W'(HIST_DEPTH);
  assign en   = acc && !eow;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  assign taken[0] = 1'b0;

  for (genvar c = 0; c < NUM_WIDTHS; c++) begin : g_cell
    mwdpf_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (en),
      .eval_i   (eval),
      .width_i  (WID_W'(MAX_WIDTH - c)),
      .sample_i (in_i.item.sample),
      .sw_i     (hist_q[MAX_WIDTH - c - 1]),
      .sw1_i    (hist_q[MAX_WIDTH - c]),
      .thr_i    (cfg_q),
      .taken_i  (taken[c]),
      .taken_o  (taken[c+1]),
      .win_o    (win[c])
    );
  end

  always_comb begin
    fired_w = '0;
    for (int c = 0; c < NUM_WIDTHS; c++) begin
      if (win[c]) begin
        fired_w = fired_w | WID_W'(MAX_WIDTH - c);
      end
    end
  end

  assign emit   = taken[NUM_WIDTHS] && (cnt_q < CNT_W'(MAX_PEAKS));
  assign is_new = (cnt_q == '0) || ((idx_q - last_q) > IDX_W'(fired_w));
  assign num    = is_new ? cnt_q : cnt_q - CNT_W'(1);

  always_comb begin
    idx_d       = idx_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (acc) begin
      out_valid_d = eow || emit;
      if (eow) begin
        out_d.kind        = KIND_DONE;
        out_d.peak_number = '0;
        out_d.position    = '0;
        out_d.height      = '0;
        out_d.peak_count  = cnt_q;
        idx_d             = '0;
        last_d            = '0;
        cnt_d             = '0;
      end else begin
        if (emit) begin
          out_d.kind        = is_new ? KIND_NEW : KIND_REPLACE;
          out_d.peak_number = num[PNUM_W-1:0];
          out_d.position    = idx_q;
          out_d.height      = in_i.item.sample;
          out_d.peak_count  = '0;
          last_d            = idx_q;
          if (is_new) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        if (idx_q != IDX_MAX) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deriv <= DERIV_RST;
      cfg_q.rise  <= RISE_RST;
      cfg_q.step  <= STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DERIV: cfg_q.deriv <= cfg_data_i[DTHR_W-1:0];
        REG_RISE:  cfg_q.rise  <= cfg_data_i[DTHR_W-1:0];
        REG_STEP:  cfg_q.step  <= cfg_data_i[STHR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      last_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (en) begin
      hist_q[0] <= in_i.item.sample;
      for (int k = 1; k < HIST_DEPTH; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  `ASSERT_NEVER(a_cnt_limit, cnt_q > CNT_W'(MAX_PEAKS), "peak count past limit")
  `ASSERT_NEVER(a_last_order, last_q > idx_q, "last peak ahead of sample index")
  `ASSERT_PROP(a_idx_sat, (en && idx_q == IDX_MAX) |=> (idx_q == IDX_MAX), "index wrapped")
  `ASSERT_PROP(a_eow_clear, (acc && eow) |=> (cnt_q == '0 && idx_q == '0 && out_valid_q && out_q.kind == KIND_DONE), "waveform end not cleared")
  `ASSERT_PROP(a_replace_cnt, (out_valid_q && out_q.kind == KIND_REPLACE) |-> (cnt_q != '0), "replace with no peak")

endmodule

FILE: rtl/core/mwdpf_cell.sv
// ----------------------------------------------------------------------------
// Peak finder width cell
// Slope line and firing test for one width; passes the taken flag down the
// row so the widest firing cell wins.
// ----------------------------------------------------------------------------
module mwdpf_cell import mwdpf_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             eval_i,
  input  logic [WID_W-1:0] width_i,
  input  sample_t          sample_i,
  input  sample_t          sw_i,
  input  sample_t          sw1_i,
  input  cfg_t             thr_i,
  input  logic             taken_i,
  output logic             taken_o,
  output logic             win_o
);

  slope_t             line_q [MAX_WIDTH];
  slope_t             d;
  slope_t             push_d;
  slope_t             old;
  logic [WID_W-1:0]   wm1;
  logic [TAP_W-1:0]   tap;
  logic signed [CMP_W-1:0] rise_diff;
  logic signed [CMP_W-1:0] step_diff;
  logic               fire;

  assign wm1 = width_i - WID_W'(1);
  assign tap = wm1[TAP_W-1:0];
  assign old = line_q[tap];

  assign d = (SLOPE_W'(sample_i) <<< 1) - SLOPE_W'(sw_i) - SLOPE_W'(sw1_i);
  assign rise_diff = CMP_W'(d) - CMP_W'(old);
  assign step_diff = CMP_W'(sample_i) - CMP_W'(sw_i);

  assign fire = eval_i
              && (CMP_W'(d) >= $signed(CMP_W'(thr_i.deriv)))
              && (rise_diff > $signed(CMP_W'(thr_i.rise)))
              && (step_diff > $signed(CMP_W'(thr_i.step)));

  assign win_o   = fire && !taken_i;
  assign taken_o = fire || taken_i;
  assign push_d  = eval_i ? d : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= push_d;
      for (int k = 1; k < MAX_WIDTH; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

endmodule
